// ----- sv/fbs_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fbs_pkg: shared types and constants of the frame byte stuffer
// Holds the result beat layout, the packet state record, register indexes
// and reset values used by the encoder, the result queue and the top level.
// -----------------------------------------------------------------------------
package fbs_pkg;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_FLAG     = 2'd1;
    localparam logic [1:0] REG_ESCAPE   = 2'd2;

    localparam logic [15:0] CAPACITY_RST = 16'd1024;
    localparam logic [7:0]  FLAG_RST     = 8'h7E;
    localparam logic [7:0]  ESCAPE_RST   = 8'h7D;

    // An escaped byte is sent with this pattern flipped.
    localparam logic [7:0]  STUFF_XOR    = 8'h20;

    // Input command codes.
    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Result queue: one item makes at most three beats, one may still wait.
    localparam int unsigned RESULTS_MAX = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        overflow;
        logic [15:0] frame_length;
    } t_result;

    typedef t_result [RESULTS_MAX-1:0] t_results;

    typedef struct packed {
        logic [15:0] out_count;
        logic        in_frame;
        logic        aborted;
    } t_state;

endpackage

// ----- sv/fbs_encoder.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fbs_encoder: single-pass stuffing logic
// Turns one input item and the current packet state into up to three result
// beats and the next packet state, with the capacity check on every write.
// -----------------------------------------------------------------------------
module fbs_encoder (
    input  fbs_pkg::t_state   i_state,
    input  logic              i_cmd,
    input  logic [7:0]        i_data_byte,
    input  logic              i_lead_flag,
    input  logic [15:0]       i_capacity,
    input  logic [7:0]        i_flag,
    input  logic [7:0]        i_escape,
    output fbs_pkg::t_state   o_next,
    output logic [1:0]        o_count,
    output fbs_pkg::t_results o_res
);

    logic [16:0]      w_cap;
    logic [16:0]      w_c0;
    logic [16:0]      w_c1;
    logic             w_lead_now;
    logic             w_lead_fit;
    logic             w_esc;
    logic             w_fit1;
    logic             w_fit2;
    fbs_pkg::t_result w_err;
    fbs_pkg::t_result w_lead;
    fbs_pkg::t_result w_a;
    fbs_pkg::t_result w_b;
    logic [1:0]       w_na;

    assign w_cap      = {1'b0, i_capacity};
    assign w_c0       = i_state.in_frame ? {1'b0, i_state.out_count} : 17'd0;
    assign w_lead_now = !i_state.in_frame && i_lead_flag;
    assign w_lead_fit = (w_c0 + 17'd1) < w_cap;
    assign w_c1       = w_lead_now ? (w_c0 + 17'd1) : w_c0;
    assign w_esc      = (i_data_byte == i_flag) || (i_data_byte == i_escape);
    assign w_fit1     = (w_c1 + 17'd1) < w_cap;
    assign w_fit2     = (w_c1 + 17'd2) < w_cap;

    // The error beat carries a zero byte and closes the frame.
    assign w_err  = '{out_byte: 8'd0, frame_end: 1'b1, overflow: 1'b1,
                      frame_length: 16'd0};
    assign w_lead = '{out_byte: i_flag, frame_end: 1'b0, overflow: 1'b0,
                      frame_length: 16'd0};

    // Beats that belong to the item itself, after any leading flag.
    always_comb begin
        w_a  = '0;
        w_b  = '0;
        w_na = 2'd1;
        if (i_cmd == fbs_pkg::CMD_DATA) begin
            if (w_esc) begin
                if (w_fit2) begin
                    w_a.out_byte = i_escape;
                    w_b.out_byte = i_data_byte ^ fbs_pkg::STUFF_XOR;
                    w_na         = 2'd2;
                end else begin
                    w_a = w_err;
                end
            end else if (w_fit1) begin
                w_a.out_byte = i_data_byte;
            end else begin
                w_a = w_err;
            end
        end else begin
            if (w_fit1) begin
                w_a.out_byte     = i_flag;
                w_a.frame_end    = 1'b1;
                w_a.frame_length = w_c1[15:0] + 16'd1;
            end else begin
                w_a = w_err;
            end
        end
    end

    always_comb begin
        o_next  = i_state;
        o_count = 2'd0;
        o_res   = '0;
        if (i_state.aborted) begin
            // Bytes are dropped; only the end command clears the packet.
            if (i_cmd == fbs_pkg::CMD_END) begin
                o_next = '0;
            end
        end else if (w_lead_now && !w_lead_fit) begin
            o_res[0]         = w_err;
            o_count          = 2'd1;
            o_next.out_count = 16'd0;
            o_next.in_frame  = (i_cmd == fbs_pkg::CMD_DATA);
            o_next.aborted   = (i_cmd == fbs_pkg::CMD_DATA);
        end else begin
            if (w_lead_now) begin
                o_res[0] = w_lead;
                o_res[1] = w_a;
                o_res[2] = w_b;
                o_count  = w_na + 2'd1;
            end else begin
                o_res[0] = w_a;
                o_res[1] = w_b;
                o_count  = w_na;
            end
            if (i_cmd == fbs_pkg::CMD_END) begin
                o_next = '0;
            end else begin
                o_next.in_frame = 1'b1;
                if (w_a.overflow) begin
                    o_next.aborted   = 1'b1;
                    o_next.out_count = w_c1[15:0];
                end else begin
                    o_next.out_count = w_c1[15:0] + {14'd0, w_na};
                end
            end
        end
    end

endmodule

// ----- sv/fbs_rbuf.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// fbs_rbuf: result beat queue
// Four-entry circular queue that takes up to three beats in one cycle and
// hands out one beat per cycle on the output channel while i_pop is high.
// -----------------------------------------------------------------------------
module fbs_rbuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_n,
    input  fbs_pkg::t_results i_data,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output fbs_pkg::t_result  o_head
);

    localparam int unsigned PtrW = $clog2(fbs_pkg::QUEUE_DEPTH);
    localparam int unsigned CntW = $clog2(fbs_pkg::QUEUE_DEPTH + 1);

    fbs_pkg::t_result r_mem [fbs_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]  r_wr_ptr;
    logic [PtrW-1:0]  r_rd_ptr;
    logic [CntW-1:0]  r_count;
    logic [CntW-1:0]  n_count;
    logic             w_pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for a full item's worth of beats even if nothing leaves.
    assign o_room  = (r_count <= CntW'(fbs_pkg::QUEUE_DEPTH - fbs_pkg::RESULTS_MAX));
    assign w_pop   = i_pop && o_valid;
    assign n_count = r_count + CntW'(i_push_n) - CntW'(w_pop);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < fbs_pkg::RESULTS_MAX; j++) begin
            if (j < int'(i_push_n)) begin
                r_mem[r_wr_ptr + PtrW'(j)] <= i_data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PtrW'(i_push_n);
            r_rd_ptr <= r_rd_ptr + PtrW'(w_pop);
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(fbs_pkg::QUEUE_DEPTH))
        else $error("result queue count beyond its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |-> o_room)
        else $error("beats pushed while the queue had no room");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_n != 2'd0) |=> o_valid)
        else $error("pushed beats did not appear at the output");

endmodule

// ----- sv/frame_byte_stuffer.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// frame_byte_stuffer: flag-delimited byte-stuffing framer
// Streams packet bytes into a stuffed frame with an optional leading flag,
// a closing flag with the frame length, and a capacity-checked abort.
// -----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid / o_ready) carries one beat per packet item: a
// payload byte (i_cmd clear) or the end command (i_cmd set). i_lead_flag is
// looked at only on the first item of a packet and adds a leading flag byte.
// The output channel (o_valid / i_ready) carries one stuffed frame byte per
// beat. The end command yields the closing flag with o_frame_end set and the
// total frame length on o_frame_length. If a write would leave no spare slot
// in the frame buffer, an error beat with o_overflow and o_frame_end set is
// sent instead, and payload items are then swallowed until the end command.
// Timing: an accepted item's beats are registered in the result queue and
// shown behind any beats still waiting there. An item makes one to three
// beats, an escaped byte a pair; the output port moves one byte per cycle
// while the receiver is ready. Dropped bytes make no beat and are taken at
// one per cycle while at most one beat waits in the four-entry result queue
// between the sides, the one condition on input while the receiver stalls.
// Reset restores the register defaults and drops any packet in progress.
// -----------------------------------------------------------------------------
module frame_byte_stuffer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_lead_flag,
    // Output channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_overflow,
    output logic [15:0] o_frame_length
);

    logic [15:0]       r_capacity;
    logic [7:0]        r_flag;
    logic [7:0]        r_escape;
    fbs_pkg::t_state   r_state;
    fbs_pkg::t_state   n_state;
    fbs_pkg::t_results w_res;
    fbs_pkg::t_result  w_head;
    logic [1:0]        w_enc_n;
    logic [1:0]        w_push_n;
    logic              w_accept;
    logic              w_cfg_wr;

    // Register file. Writes land in the access phase; pready never stalls.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= fbs_pkg::CAPACITY_RST;
            r_flag     <= fbs_pkg::FLAG_RST;
            r_escape   <= fbs_pkg::ESCAPE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                fbs_pkg::REG_CAPACITY: r_capacity <= pwdata[15:0];
                fbs_pkg::REG_FLAG:     r_flag     <= pwdata[7:0];
                fbs_pkg::REG_ESCAPE:   r_escape   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            fbs_pkg::REG_CAPACITY: prdata = {16'd0, r_capacity};
            fbs_pkg::REG_FLAG:     prdata = {24'd0, r_flag};
            fbs_pkg::REG_ESCAPE:   prdata = {24'd0, r_escape};
            default:               prdata = 32'd0;
        endcase
    end

    // The whole item is stuffed in the cycle it is accepted; its beats go
    // straight into the result queue and the packet state moves on.
    assign w_accept = i_valid && o_ready;
    assign w_push_n = w_accept ? w_enc_n : 2'd0;

    fbs_encoder u_encoder (
        .i_state     (r_state),
        .i_cmd       (i_cmd),
        .i_data_byte (i_data_byte),
        .i_lead_flag (i_lead_flag),
        .i_capacity  (r_capacity),
        .i_flag      (r_flag),
        .i_escape    (r_escape),
        .o_next      (n_state),
        .o_count     (w_enc_n),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    fbs_rbuf u_rbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_n (w_push_n),
        .i_data   (w_res),
        .i_pop    (i_ready),
        .o_room   (o_ready),
        .o_valid  (o_valid),
        .o_head   (w_head)
    );

    assign o_out_byte     = w_head.out_byte;
    assign o_frame_end    = w_head.frame_end;
    assign o_overflow     = w_head.overflow;
    assign o_frame_length = w_head.frame_length;

    // A dropping packet is always open; an end command always closes it.
    a_abort_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.aborted |-> r_state.in_frame)
        else $error("aborted packet state outside a frame");

    a_end_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == fbs_pkg::CMD_END)) |=> (r_state == '0))
        else $error("end command left packet state behind");

    a_end_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_cmd == fbs_pkg::CMD_END) && !r_state.aborted)
        |-> (w_push_n != 2'd0))
        else $error("end command of a live packet made no beat");

endmodule

// ----- verif/tb_frame_byte_stuffer.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_frame_byte_stuffer: self-checking testbench of the frame byte stuffer
// A directed table first covers reset values, both delimiters, escaping, the
// capacity rule and every abort path. Random packets follow under several
// register settings, with random gaps and stalls on both channels. Every
// output beat is compared against a cycle-free model of the framer.
// -----------------------------------------------------------------------------
module tb_frame_byte_stuffer;

    // The run is cut off here. A correct run needs a small fraction of it.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    // Receiver hold-off that fills the result queue and stalls the input.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    // A few quiet cycles once every owed beat is out, before a register
    // write or the end of the run.
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned TAIL_CYCLES     = 24;
    // Random items per register setting.
    localparam int unsigned PHASE_ITEMS     = 82;
    localparam int unsigned PHASES          = 4;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    // One row of the directed table: an input item, or a register write.
    typedef struct {
        t_row_kind        kind;
        logic             cmd;
        logic [7:0]       data;
        logic             lead;
        bit               known;
        fbs_pkg::t_result want;
        logic [1:0]       reg_idx;
        logic [31:0]      reg_val;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = fbs_pkg::CMD_DATA;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_lead_flag = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;
    logic        o_overflow;
    logic [15:0] o_frame_length;

    // Mirror of the framer's registers and packet state.
    int unsigned cap_bytes = 32'(fbs_pkg::CAPACITY_RST);
    logic [7:0]  flag_val = fbs_pkg::FLAG_RST;
    logic [7:0]  esc_val = fbs_pkg::ESCAPE_RST;
    int unsigned frm_count = 0;
    bit          frm_open = 1'b0;
    bit          frm_dropping = 1'b0;

    // Stuffed bytes still owed by the block, oldest first.
    fbs_pkg::t_result frame_bytes_due[$];
    t_row             plan[$];

    int unsigned mismatches = 0;
    int unsigned sent_items = 0;
    int unsigned cycle_count = 0;
    bit          valid_up = 1'b0;
    bit          calm_tx = 1'b0;
    bit          calm_rx = 1'b0;
    bit          long_hold = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frame_byte_stuffer i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_lead_flag    (i_lead_flag),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_overflow     (o_overflow),
        .o_frame_length (o_frame_length)
    );

    function automatic fbs_pkg::t_result frame_beat(logic [7:0] b, logic fend,
                                                    logic ovf, logic [15:0] len);
        fbs_pkg::t_result r;
        r.out_byte     = b;
        r.frame_end    = fend;
        r.overflow     = ovf;
        r.frame_length = len;
        return r;
    endfunction

    // The buffer must always keep one slot free after a write.
    function automatic bit room_for(int unsigned n);
        return frm_count + n < cap_bytes;
    endfunction

    // Works out the beats one input item makes and advances the packet state.
    function automatic int stuff_item(input logic cmd, input logic [7:0] dbyte,
                                      input logic lead, output fbs_pkg::t_results beats);
        fbs_pkg::t_result abort_beat;
        int               n;
        abort_beat = frame_beat(8'h00, 1'b1, 1'b1, 16'h0000);
        n = 0;
        beats = '0;
        // After an overflow, payload is swallowed and the end command only
        // clears the packet without a beat.
        if (frm_dropping) begin
            if (cmd == fbs_pkg::CMD_END) begin
                frm_dropping = 1'b0;
                frm_open = 1'b0;
                frm_count = 0;
            end
            return 0;
        end
        if (!frm_open) begin
            frm_open = 1'b1;
            frm_count = 0;
            if (lead) begin
                if (!room_for(1)) begin
                    beats[n] = abort_beat;
                    n++;
                    if (cmd == fbs_pkg::CMD_END)
                        frm_open = 1'b0;
                    else
                        frm_dropping = 1'b1;
                    return n;
                end
                beats[n] = frame_beat(flag_val, 1'b0, 1'b0, 16'h0000);
                n++;
                frm_count++;
            end
        end
        if (cmd == fbs_pkg::CMD_DATA) begin
            if (dbyte == flag_val || dbyte == esc_val) begin
                if (!room_for(2)) begin
                    beats[n] = abort_beat;
                    frm_dropping = 1'b1;
                    return n + 1;
                end
                beats[n] = frame_beat(esc_val, 1'b0, 1'b0, 16'h0000);
                beats[n + 1] = frame_beat(dbyte ^ fbs_pkg::STUFF_XOR, 1'b0, 1'b0,
                                          16'h0000);
                n += 2;
                frm_count += 2;
            end else begin
                if (!room_for(1)) begin
                    beats[n] = abort_beat;
                    frm_dropping = 1'b1;
                    return n + 1;
                end
                beats[n] = frame_beat(dbyte, 1'b0, 1'b0, 16'h0000);
                n++;
                frm_count++;
            end
            return n;
        end
        // End command: the closing flag carries the whole frame length.
        if (!room_for(1)) begin
            beats[n] = abort_beat;
        end else begin
            frm_count++;
            beats[n] = frame_beat(flag_val, 1'b1, 1'b0, 16'(frm_count));
        end
        frm_open = 1'b0;
        frm_count = 0;
        return n + 1;
    endfunction

    function automatic t_row row_item(logic cmd, logic [7:0] data, logic lead);
        t_row r;
        r.kind    = ROW_ITEM;
        r.cmd     = cmd;
        r.data    = data;
        r.lead    = lead;
        r.known   = 1'b0;
        r.want    = '0;
        r.reg_idx = fbs_pkg::REG_CAPACITY;
        r.reg_val = 32'd0;
        return r;
    endfunction

    function automatic t_row row_known(logic cmd, logic [7:0] data, logic lead,
                                       fbs_pkg::t_result want);
        t_row r;
        r = row_item(cmd, data, lead);
        r.known = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic t_row row_reg(logic [1:0] idx, logic [31:0] val);
        t_row r;
        r = row_item(fbs_pkg::CMD_DATA, 8'h00, 1'b0);
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic drop_valid();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    // Offers one item after a random gap and holds it until it is taken. A
    // row with a known outcome fixes the item's last beat; any beat before
    // it comes from the model.
    task automatic offer_item(input logic cmd, input logic [7:0] dbyte,
                              input logic lead, input bit known,
                              input fbs_pkg::t_result want);
        int unsigned       gap;
        fbs_pkg::t_results beats;
        int                n;
        gap = calm_tx ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            drop_valid();
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= dbyte;
        i_lead_flag <= lead;
        valid_up = 1'b1;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        n = stuff_item(cmd, dbyte, lead, beats);
        for (int k = 0; k < n; k++)
            frame_bytes_due.push_back((known && k == n - 1) ? want : beats[k]);
        sent_items++;
    endtask

    // Stops offering and waits until every owed beat is out, then lets a
    // few quiet cycles pass.
    task automatic wait_idle();
        drop_valid();
        do @(posedge i_clk); while (frame_bytes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then the access cycle; the register takes the value at
    // the edge where penable and pready are both high. The bus then returns to
    // idle before the next transfer.
    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            fbs_pkg::REG_CAPACITY: cap_bytes = 32'(val[15:0]);
            fbs_pkg::REG_FLAG:     flag_val = val[7:0];
            fbs_pkg::REG_ESCAPE:   esc_val = val[7:0];
            default:               ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_config(input int unsigned cap, input logic [7:0] flag,
                              input logic [7:0] esc);
        wait_idle();
        reg_write(fbs_pkg::REG_CAPACITY, cap);
        reg_write(fbs_pkg::REG_FLAG, {24'd0, flag});
        reg_write(fbs_pkg::REG_ESCAPE, {24'd0, esc});
    endtask

    // A well-formed packet: payload rich in delimiter and escape values,
    // then the end command. lead_flag is random on every item; only the
    // first one of a packet should matter.
    task automatic send_packet(input int unsigned max_len);
        int unsigned len;
        int unsigned pick;
        logic [7:0]  dbyte;
        len = $urandom_range(0, max_len);
        for (int unsigned k = 0; k < len; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 2)
                dbyte = flag_val;
            else if (pick < 4)
                dbyte = esc_val;
            else
                dbyte = 8'($urandom_range(0, 255));
            offer_item(fbs_pkg::CMD_DATA, dbyte, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
        offer_item(fbs_pkg::CMD_END, 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'b0, '0);
    endtask

    // Receiver: a random stall before each beat, runs with no stall at all
    // when calm_rx is set, and one long hold-off on request.
    initial begin : receiver
        int unsigned stall;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm_rx ? 0 : $urandom_range(0, 13);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_ready));
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end
        end
    end

    // Every accepted output beat is matched against the oldest owed beat.
    always @(posedge i_clk) begin : check_beats
        fbs_pkg::t_result got;
        fbs_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            got = frame_beat(o_out_byte, o_frame_end, o_overflow, o_frame_length);
            if (frame_bytes_due.size() == 0) begin
                $error("unexpected beat: out_byte %02h frame_end %0b overflow %0b",
                       got.out_byte, got.frame_end, got.overflow);
                mismatches++;
            end else begin
                want = frame_bytes_due.pop_front();
                if (got.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                    mismatches++;
                end
                if (got.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0b, got %0b",
                           want.frame_end, got.frame_end);
                    mismatches++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    mismatches++;
                end
                if (got.frame_length !== want.frame_length) begin
                    $error("frame_length: expected %0d, got %0d",
                           want.frame_length, got.frame_length);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        fbs_pkg::t_result abort_beat;
        int unsigned      phase_start;
        bit               paused;
        bit               squeezed;
        abort_beat = frame_beat(8'h00, 1'b1, 1'b1, 16'h0000);
        squeezed = 1'b0;

        // Reset register values first: empty packets with and without the
        // leading flag, escaping of both special bytes, byte extremes.
        plan.push_back(row_known(fbs_pkg::CMD_END, 8'h00, 1'b0,
                                 frame_beat(fbs_pkg::FLAG_RST, 1'b1, 1'b0, 16'd1)));
        plan.push_back(row_known(fbs_pkg::CMD_END, 8'hFF, 1'b1,
                                 frame_beat(fbs_pkg::FLAG_RST, 1'b1, 1'b0, 16'd2)));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h00, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'hFF, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, fbs_pkg::FLAG_RST, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, fbs_pkg::ESCAPE_RST, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h55, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'hAA, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h00, 1'b0));
        // Capacity of one: no write ever fits. Covers the abort on payload,
        // dropped bytes, the silent end, and the leading flag overflowing
        // both on an end command and on a payload byte.
        plan.push_back(row_reg(fbs_pkg::REG_CAPACITY, 32'd1));
        plan.push_back(row_known(fbs_pkg::CMD_DATA, 8'h33, 1'b0, abort_beat));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h44, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h00, 1'b0));
        plan.push_back(row_known(fbs_pkg::CMD_END, 8'h00, 1'b1, abort_beat));
        plan.push_back(row_known(fbs_pkg::CMD_DATA, 8'h10, 1'b1, abort_beat));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h00, 1'b0));
        // Zero capacity.
        plan.push_back(row_reg(fbs_pkg::REG_CAPACITY, 32'd0));
        plan.push_back(row_known(fbs_pkg::CMD_DATA, 8'h01, 1'b0, abort_beat));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h00, 1'b0));
        // Capacity of three with delimiter 0x00 and escape 0xFF: an escape
        // pair that does not fit after the leading flag, and a closing flag
        // that does not fit.
        plan.push_back(row_reg(fbs_pkg::REG_CAPACITY, 32'd3));
        plan.push_back(row_reg(fbs_pkg::REG_FLAG, 32'h00));
        plan.push_back(row_reg(fbs_pkg::REG_ESCAPE, 32'hFF));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h00, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h00, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'hFF, 1'b0));
        plan.push_back(row_known(fbs_pkg::CMD_END, 8'h00, 1'b0, abort_beat));
        // Largest capacity with the delimiter and escape values swapped to
        // the opposite extremes.
        plan.push_back(row_reg(fbs_pkg::REG_CAPACITY, 32'hFFFF));
        plan.push_back(row_reg(fbs_pkg::REG_FLAG, 32'hFF));
        plan.push_back(row_reg(fbs_pkg::REG_ESCAPE, 32'h00));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'hFF, 1'b1));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h00, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_DATA, 8'h20, 1'b0));
        plan.push_back(row_item(fbs_pkg::CMD_END, 8'h7E, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_REG) begin
                wait_idle();
                reg_write(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                offer_item(plan[r].cmd, plan[r].data, plan[r].lead, plan[r].known,
                           plan[r].want);
            end
        end

        // Random packets under reset values, a tiny capacity that aborts
        // often, the largest capacity, and a mid-size one. Delimiter and
        // escape are random in the later settings and may coincide.
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       set_config(32'(fbs_pkg::CAPACITY_RST), fbs_pkg::FLAG_RST,
                                    fbs_pkg::ESCAPE_RST);
                1:       set_config($urandom_range(1, 16), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                2:       set_config(32'hFFFF, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
                default: set_config($urandom_range(6, 48), 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            phase_start = sent_items;
            paused = 1'b0;
            while (sent_items - phase_start < PHASE_ITEMS) begin
                calm_tx = ($urandom_range(0, 4) == 0);
                calm_rx = ($urandom_range(0, 4) == 0);
                if (ph == 0 && !squeezed && sent_items - phase_start > 30) begin
                    // Receiver stops for a long while as items keep coming
                    // back to back, so the result queue fills and the input
                    // side has to stall.
                    squeezed = 1'b1;
                    long_hold = 1'b1;
                    calm_tx = 1'b1;
                    send_packet(24);
                end else if (!paused && sent_items - phase_start > PHASE_ITEMS / 2) begin
                    // Sender goes quiet until the block has drained.
                    paused = 1'b1;
                    wait_idle();
                end else if ($urandom_range(0, 9) == 0) begin
                    offer_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)), 1'b0, '0);
                end else begin
                    send_packet(($urandom_range(0, 7) == 0) ? 40 : 10);
                end
            end
        end

        calm_rx = 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/fbs_pkg.sv
sv/fbs_encoder.sv
sv/fbs_rbuf.sv
sv/frame_byte_stuffer.sv
verif/tb_frame_byte_stuffer.sv
